/* src/skt_pkg.sv */
// Package for the sorted key table: request/response structs, status and
// operation codes, default capacity. No dependencies.
package skt_pkg;

    localparam int DefaultCapacity = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] payload;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_payload;
        logic [6:0]  entry_count;
    } rsp_t;

endpackage

/* src/sorted_key_table.sv */
// Sorted key table: entries held densely in ascending key order in two
// synchronous memories (keys, payloads). Depends on skt_pkg.
//
// One request at a time. The key is located by a linear walk from slot 0,
// each slot visited with a memory read, then a compare, until a key at or
// above the request is found or the walk runs off the end. An execute
// step follows. Insert or remove then moves the entries behind the slot
// one position, over the single read and write port of each memory. The
// output register is then loaded, which may wait on a stall at the output;
// the next request is taken only once the result is loaded.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::DefaultCapacity
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  skt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output skt_pkg::rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
    localparam logic [CW-1:0] One = CW'(1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_EXEC     = 3'd3;
    localparam logic [2:0] S_MOVE_RD  = 3'd4;
    localparam logic [2:0] S_MOVE_WR  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [31:0] key_mem [CAPACITY];
    logic [31:0] pl_mem  [CAPACITY];

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic          hit_reg, hit_next;
    logic [1:0]    op_reg;
    logic [31:0]   key_reg;
    logic [31:0]   pl_reg;
    logic [1:0]    status_reg, status_next;
    logic [31:0]   rd_reg, rd_next;
    logic          out_valid_reg, out_valid_next;
    skt_pkg::rsp_t out_reg, out_next;

    logic [CW-1:0] rd_addr;
    logic [31:0]   rd_key_q, rd_pl_q;
    logic          key_we, pl_we;
    logic [CW-1:0] wr_addr;
    logic [31:0]   wr_key, wr_pl;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr[AW-1:0]] <= wr_key;
        end
        if (pl_we)
        begin
            pl_mem[wr_addr[AW-1:0]] <= wr_pl;
        end
        rd_key_q <= key_mem[rd_addr[AW-1:0]];
        rd_pl_q  <= pl_mem[rd_addr[AW-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        slot_next      = slot_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rd_addr        = ptr_reg;
        key_we         = 1'b0;
        pl_we          = 1'b0;
        wr_addr        = ptr_reg;
        wr_key         = rd_key_q;
        wr_pl          = rd_pl_q;

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ptr_next    = '0;
                    hit_next    = 1'b0;
                    status_next = skt_pkg::ST_OK;
                    rd_next     = '0;
                    state_next  = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    slot_next  = ptr_reg;
                    hit_next   = 1'b0;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (rd_key_q >= key_reg)
                begin
                    slot_next  = ptr_reg;
                    hit_next   = (rd_key_q == key_reg);
                    if (rd_key_q == key_reg && op_reg == skt_pkg::OP_SEARCH)
                    begin
                        rd_next = rd_pl_q;
                    end
                    state_next = S_EXEC;
                end
                else
                begin
                    ptr_next   = ptr_reg + One;
                    state_next = S_SCAN_RD;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    skt_pkg::OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            status_next = skt_pkg::ST_DUP;
                        end
                        else if (count_reg == CapCount)
                        begin
                            status_next = skt_pkg::ST_FULL;
                        end
                        else
                        begin
                            ptr_next   = count_reg;
                            state_next = S_MOVE_RD;
                        end
                    end
                    skt_pkg::OP_SEARCH:
                    begin
                        if (!hit_reg)
                        begin
                            status_next = skt_pkg::ST_MISSING;
                        end
                    end
                    skt_pkg::OP_UPDATE:
                    begin
                        if (hit_reg)
                        begin
                            pl_we   = 1'b1;
                            wr_addr = slot_reg;
                            wr_pl   = pl_reg;
                        end
                        else
                        begin
                            status_next = skt_pkg::ST_MISSING;
                        end
                    end
                    skt_pkg::OP_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            ptr_next   = slot_reg;
                            state_next = S_MOVE_RD;
                        end
                        else
                        begin
                            status_next = skt_pkg::ST_MISSING;
                        end
                    end
                    default:
                    begin
                        status_next = skt_pkg::ST_MISSING;
                    end
                endcase
            end
            S_MOVE_RD:
            begin
                if (op_reg == skt_pkg::OP_INSERT)
                begin
                    // shifting up, from the top entry down to the slot
                    if (ptr_reg == slot_reg)
                    begin
                        key_we     = 1'b1;
                        pl_we      = 1'b1;
                        wr_addr    = slot_reg;
                        wr_key     = key_reg;
                        wr_pl      = pl_reg;
                        count_next = count_reg + One;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr    = ptr_reg - One;
                        state_next = S_MOVE_WR;
                    end
                end
                else
                begin
                    if (ptr_reg + One >= count_reg)
                    begin
                        count_next = count_reg - One;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr    = ptr_reg + One;
                        state_next = S_MOVE_WR;
                    end
                end
            end
            S_MOVE_WR:
            begin
                key_we     = 1'b1;
                pl_we      = 1'b1;
                wr_addr    = ptr_reg;
                ptr_next   = (op_reg == skt_pkg::OP_INSERT) ? ptr_reg - One : ptr_reg + One;
                state_next = S_MOVE_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.read_payload = rd_reg;
                    out_next.entry_count  = 7'(count_reg);
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            op_reg  <= req.operation;
            key_reg <= req.key;
            pl_reg  <= req.payload;
        end
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        out_reg    <= out_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CapCount)
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + One)
                 || (count_reg == $past(count_reg) - One))
        else $error("entry count moved by more than one");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !key_we && !pl_we)
        else $error("memory write outside an operation");

    a_count_only_on_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |-> (state_reg == S_MOVE_RD))
        else $error("entry count changed outside a move");

endmodule

/* dv/testbench.sv */
// Testbench for sorted_key_table: random and directed requests with an
// in-bench sorted-table predictor and a scoreboard class. Depends on skt_pkg.
module testbench;

    localparam int Capacity = skt_pkg::DefaultCapacity;
    localparam int IdleLimit = 20000;

    class table_scoreboard;
        logic [31:0] keys[$];
        logic [31:0] payloads[$];
        skt_pkg::rsp_t expected_rsps[$];
        int mismatches;

        function void note_request(skt_pkg::req_t r);
            skt_pkg::rsp_t e;
            int slot;
            bit hit;
            slot = 0;
            while (slot < keys.size() && keys[slot] < r.key)
                slot++;
            hit = slot < keys.size() && keys[slot] == r.key;
            e.status = skt_pkg::ST_OK;
            e.read_payload = '0;
            case (r.operation)
                skt_pkg::OP_INSERT:
                    if (hit)
                        e.status = skt_pkg::ST_DUP;
                    else if (keys.size() >= Capacity)
                        e.status = skt_pkg::ST_FULL;
                    else
                    begin
                        keys.insert(slot, r.key);
                        payloads.insert(slot, r.payload);
                    end
                skt_pkg::OP_SEARCH:
                    if (hit)
                        e.read_payload = payloads[slot];
                    else
                        e.status = skt_pkg::ST_MISSING;
                skt_pkg::OP_UPDATE:
                    if (hit)
                        payloads[slot] = r.payload;
                    else
                        e.status = skt_pkg::ST_MISSING;
                default:
                    if (hit)
                    begin
                        keys.delete(slot);
                        payloads.delete(slot);
                    end
                    else
                        e.status = skt_pkg::ST_MISSING;
            endcase
            e.entry_count = 7'(keys.size());
            expected_rsps.push_back(e);
        endfunction

        function void check_response(skt_pkg::rsp_t got);
            skt_pkg::rsp_t e;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %p", got);
                return;
            end
            e = expected_rsps.pop_front();
            if (got !== e)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    skt_pkg::req_t req;
    logic rsp_valid;
    logic rsp_ready;
    skt_pkg::rsp_t rsp;
    table_scoreboard sb;
    logic [31:0] key_pool[$];
    int idle_cycles = 0;

    sorted_key_table #(.CAPACITY(Capacity)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Valid drops only across a gap; back-to-back requests keep it high.
    task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] p);
        skt_pkg::req_t r;
        int gap;
        r.operation = op;
        r.key = k;
        r.payload = p;
        gap = gap_length();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // Keys mostly drawn from a small pool so hits and removes are common.
    function automatic logic [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);
    end

    // Receiver stalls: mostly ready, occasional short or long holds.
    initial
    begin
        int hold;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 8);
            repeat (hold) @(posedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                rsp_ready <= 1'b0;
                hold = gap_length() + 1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("sorted_key_table: mismatch");
            $finish;
        end
    end

    initial
    begin
        int op;
        logic [31:0] k;
        sb = new();
        req_valid = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table misses, key extremes, duplicates, full table.
        send_request(skt_pkg::OP_SEARCH, 32'h0, 32'h0);
        send_request(skt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(skt_pkg::OP_UPDATE, 32'h5, 32'h1);
        send_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(skt_pkg::OP_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_request(skt_pkg::OP_INSERT, 32'h8000_0000, 32'h0);
        send_request(skt_pkg::OP_INSERT, 32'h0, 32'h1234_5678);
        send_request(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_request(skt_pkg::OP_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(skt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0);
        send_request(skt_pkg::OP_REMOVE, 32'h0, 32'h0);
        send_request(skt_pkg::OP_SEARCH, 32'h0, 32'h0);
        send_request(skt_pkg::OP_REMOVE, 32'h8000_0000, 32'hFFFF_FFFF);
        for (int i = 0; i < Capacity; i++)
            send_request(skt_pkg::OP_INSERT, $urandom(), $urandom());
        send_request(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h1);
        send_request(skt_pkg::OP_INSERT, 32'h7, 32'h1);
        send_request(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h0);

        // Random phases alternate between insert-biased and evenly mixed operations.
        for (int n = 0; n < 480; n++)
        begin
            if (n % 150 == 0)
                key_pool = sb.keys;
            op = $urandom_range(0, 3);
            if ((n / 75) % 2 == 0 && $urandom_range(0, 1) == 0)
                op = skt_pkg::OP_INSERT;
            k = pick_key();
            if (op == skt_pkg::OP_INSERT && $urandom_range(0, 1) == 0)
                k = $urandom();
            if (op == skt_pkg::OP_INSERT)
                key_pool.push_back(k);
            send_request(op[1:0], k, $urandom());
        end

        // Drain what is left, then verify emptiness.
        while (sb.keys.size() > 0)
            send_request(skt_pkg::OP_REMOVE, sb.keys[$urandom_range(0, sb.keys.size() - 1)],
                         32'h0);
        send_request(skt_pkg::OP_SEARCH, 32'h0, 32'h0);
        req_valid <= 1'b0;

        while (sb.expected_rsps.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_rsps.size() == 0)
            $display("sorted_key_table: match");
        else
            $display("sorted_key_table: mismatch");
        $finish;
    end
endmodule

/* filelist.f */
src/skt_pkg.sv
src/sorted_key_table.sv
dv/testbench.sv
